/* sv/sha1_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-1 digest package
// Shared constants, types and round functions for the SHA-1 digest block.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int WORD_W       = 32;
    localparam int BLOCK_BYTES  = 64;
    localparam int BLOCK_BITS   = BLOCK_BYTES * 8;
    localparam int ROUNDS       = 80;
    localparam int LEN_POS      = 56;
    localparam int DIGEST_WORDS = 5;
    localparam int COUNT_W      = 61;
    localparam int POS_W        = 6;
    localparam int ROUND_W      = 7;
    localparam int WNUM_W       = 3;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 40;

    // initial chaining values
    localparam logic [WORD_W-1:0] H_INIT0 = 32'h67452301;
    localparam logic [WORD_W-1:0] H_INIT1 = 32'hEFCDAB89;
    localparam logic [WORD_W-1:0] H_INIT2 = 32'h98BADCFE;
    localparam logic [WORD_W-1:0] H_INIT3 = 32'h10325476;
    localparam logic [WORD_W-1:0] H_INIT4 = 32'hC3D2E1F0;

    // round constants
    localparam logic [WORD_W-1:0] K_CH  = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_PA1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_MAJ = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_PA2 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_ADD   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    // what follows a compression
    typedef enum logic [1:0] {
        AFT_IDLE = 2'd0,
        AFT_PAD  = 2'd1,
        AFT_OUT  = 2'd2
    } t_after;

    function automatic logic [WORD_W-1:0] round_f(
        input logic [ROUND_W-1:0] rnd,
        input logic [WORD_W-1:0]  b,
        input logic [WORD_W-1:0]  c,
        input logic [WORD_W-1:0]  d
    );
        logic [WORD_W-1:0] f;
        if (rnd < ROUND_W'(20)) begin
            f = (b & c) | (~b & d);
        end else if (rnd < ROUND_W'(40)) begin
            f = b ^ c ^ d;
        end else if (rnd < ROUND_W'(60)) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] rnd);
        logic [WORD_W-1:0] k;
        if (rnd < ROUND_W'(20)) begin
            k = K_CH;
        end else if (rnd < ROUND_W'(40)) begin
            k = K_PA1;
        end else if (rnd < ROUND_W'(60)) begin
            k = K_MAJ;
        end else begin
            k = K_PA2;
        end
        return k;
    endfunction

endpackage

/* sv/sha1_message_digest_top.sv */
// ----------------------------------------------------------------------------
// SHA-1 message digest, byte-stream input
// Hashes a message taken one byte per beat, pads it and returns five words.
// ----------------------------------------------------------------------------
// Compression: the beat that fills a block loads the working registers, then 80
//   rounds run, one round per cycle, and then the chain is updated.
// End of message: pad one byte per cycle up to the block end, compress once or
//   twice, then offer five digest beats.
// No input byte is taken while the block pads, compresses or offers a digest.
// Reset: synchronous, active low; clears sequencer and byte count, loads chain.
module sha1_message_digest_top
    import sha1_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]             s_axis_tuser,   // [0] has_byte
    input  logic                   s_axis_tlast,   // end_of_message
    // digest stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] digest_word,
                                                   // [34:32] word_number, zero pad
    output logic                   m_axis_tlast    // last_word
);

    // control state
    t_state               r_state,  n_state;
    t_after               r_after,  n_after;
    logic [ROUND_W-1:0]   r_round,  n_round;
    logic [POS_W-1:0]     r_pos,    n_pos;     // byte position in the block
    logic [COUNT_W-1:0]   r_count,  n_count;   // message bytes taken
    logic                 r_mark,   n_mark;    // 0x80 marker already placed
    logic                 r_lenblk, n_lenblk;  // this block carries the length
    logic [WNUM_W-1:0]    r_wnum,   n_wnum;
    logic [WORD_W-1:0]    r_h [DIGEST_WORDS];
    logic [WORD_W-1:0]    n_h [DIGEST_WORDS];

    // payload: block buffer doubles as the schedule window, word 0 on top
    logic [BLOCK_BITS-1:0] r_blk, n_blk;
    logic [WORD_W-1:0]     r_a, r_b, r_c, r_d, r_e;
    logic [WORD_W-1:0]     n_a, n_b, n_c, n_d, n_e;

    logic                 in_beat, out_beat;
    logic [WORD_W-1:0]    w0, w2, w8, w13, w_new, t_sum;
    logic [63:0]          len_bits;
    logic [7:0]           len_byte, pad_byte;

    assign in_beat  = s_axis_tvalid & s_axis_tready;
    assign out_beat = m_axis_tvalid & m_axis_tready;

    // schedule taps: W[r], W[r+2], W[r+8], W[r+13] of the 16-word window
    assign w0    = r_blk[BLOCK_BITS-1         -: WORD_W];
    assign w2    = r_blk[BLOCK_BITS-1-2*WORD_W  -: WORD_W];
    assign w8    = r_blk[BLOCK_BITS-1-8*WORD_W  -: WORD_W];
    assign w13   = r_blk[BLOCK_BITS-1-13*WORD_W -: WORD_W];
    assign w_new = {(w13[WORD_W-2:0] ^ w8[WORD_W-2:0] ^ w2[WORD_W-2:0] ^ w0[WORD_W-2:0]),
                    (w13[WORD_W-1]   ^ w8[WORD_W-1]   ^ w2[WORD_W-1]   ^ w0[WORD_W-1])};

    // shared round adder
    assign t_sum = {r_a[WORD_W-6:0], r_a[WORD_W-1:WORD_W-5]}
                 + round_f(r_round, r_b, r_c, r_d) + r_e + round_k(r_round) + w0;

    // big-endian bit length, one byte per position 56..63
    assign len_bits = {r_count, 3'b000};
    assign len_byte = len_bits[{~r_pos[2:0], 3'b000} +: 8];
    assign pad_byte = !r_mark                                  ? PAD_MARK :
                      (r_pos >= POS_W'(LEN_POS) && r_lenblk)   ? len_byte : 8'h00;

    always_comb begin
        n_state  = r_state;
        n_after  = r_after;
        n_round  = r_round;
        n_pos    = r_pos;
        n_count  = r_count;
        n_mark   = r_mark;
        n_lenblk = r_lenblk;
        n_wnum   = r_wnum;
        n_h      = r_h;
        n_blk    = r_blk;
        n_a      = r_a;
        n_b      = r_b;
        n_c      = r_c;
        n_d      = r_d;
        n_e      = r_e;

        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    if (s_axis_tuser[0]) begin
                        n_blk   = {r_blk[BLOCK_BITS-9:0], s_axis_tdata};
                        n_pos   = r_pos + POS_W'(1);
                        n_count = r_count + COUNT_W'(1);
                    end
                    if (s_axis_tlast) begin
                        n_mark = 1'b0;
                    end
                    if (s_axis_tuser[0] && r_pos == POS_W'(BLOCK_BYTES-1)) begin
                        // block full: compress, then pad if this was the end
                        n_state = S_ROUND;
                        n_round = '0;
                        n_after = s_axis_tlast ? AFT_PAD : AFT_IDLE;
                        {n_a, n_b, n_c, n_d, n_e} = {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
                    end else if (s_axis_tlast) begin
                        n_state = S_PAD;
                    end
                end
            end

            S_PAD: begin
                n_blk = {r_blk[BLOCK_BITS-9:0], pad_byte};
                n_pos = r_pos + POS_W'(1);
                if (!r_mark) begin
                    n_mark   = 1'b1;
                    n_lenblk = (r_pos < POS_W'(LEN_POS));
                end
                if (r_pos == POS_W'(BLOCK_BYTES-1)) begin
                    n_state  = S_ROUND;
                    n_round  = '0;
                    n_after  = (r_mark && r_lenblk) ? AFT_OUT : AFT_PAD;
                    n_lenblk = 1'b1;
                    {n_a, n_b, n_c, n_d, n_e} = {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
                end
            end

            S_ROUND: begin
                n_a     = t_sum;
                n_b     = r_a;
                n_c     = {r_b[1:0], r_b[WORD_W-1:2]};
                n_d     = r_c;
                n_e     = r_d;
                n_blk   = {r_blk[BLOCK_BITS-WORD_W-1:0], w_new};
                n_round = r_round + ROUND_W'(1);
                if (r_round == ROUND_W'(ROUNDS-1)) begin
                    n_state = S_ADD;
                end
            end

            S_ADD: begin
                n_h[0] = r_h[0] + r_a;
                n_h[1] = r_h[1] + r_b;
                n_h[2] = r_h[2] + r_c;
                n_h[3] = r_h[3] + r_d;
                n_h[4] = r_h[4] + r_e;
                case (r_after)
                    AFT_PAD: n_state = S_PAD;
                    AFT_OUT: begin
                        n_state = S_OUT;
                        n_wnum  = '0;
                    end
                    default: n_state = S_IDLE;
                endcase
            end

            S_OUT: begin
                if (out_beat) begin
                    // rotate the next word to the head
                    for (int i = 0; i < DIGEST_WORDS; i++) begin
                        n_h[i] = r_h[(i + 1) % DIGEST_WORDS];
                    end
                    n_wnum = r_wnum + WNUM_W'(1);
                    if (r_wnum == WNUM_W'(DIGEST_WORDS-1)) begin
                        n_h[0]  = H_INIT0;
                        n_h[1]  = H_INIT1;
                        n_h[2]  = H_INIT2;
                        n_h[3]  = H_INIT3;
                        n_h[4]  = H_INIT4;
                        n_count = '0;
                        n_pos   = '0;
                        n_state = S_IDLE;
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_after  <= AFT_IDLE;
            r_round  <= '0;
            r_pos    <= '0;
            r_count  <= '0;
            r_mark   <= 1'b0;
            r_lenblk <= 1'b0;
            r_wnum   <= '0;
            r_h[0]   <= H_INIT0;
            r_h[1]   <= H_INIT1;
            r_h[2]   <= H_INIT2;
            r_h[3]   <= H_INIT3;
            r_h[4]   <= H_INIT4;
        end else begin
            r_state  <= n_state;
            r_after  <= n_after;
            r_round  <= n_round;
            r_pos    <= n_pos;
            r_count  <= n_count;
            r_mark   <= n_mark;
            r_lenblk <= n_lenblk;
            r_wnum   <= n_wnum;
            r_h      <= n_h;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_d   <= n_d;
        r_e   <= n_e;
    end

    // input is taken only between blocks; digest words come from the chain head
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {{(OUT_TDATA_W-WORD_W-WNUM_W){1'b0}}, r_wnum, r_h[0]};
    assign m_axis_tlast  = (r_wnum == WNUM_W'(DIGEST_WORDS-1));

    // never take a byte while a digest is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while digest output pending");

    // chain update only right after the final round
    a_add_after_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> ($past(r_state) == S_ROUND &&
                                $past(r_round) == ROUND_W'(ROUNDS-1)))
        else $error("chain update without a full round sequence");

    // the last digest beat returns the block to an empty message
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && m_axis_tlast) |=> (s_axis_tready && r_count == '0 && r_pos == '0))
        else $error("message state not cleared after digest");

endmodule
